### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the deframer RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle, quiet during reset
`define ASSERT_SAME(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// implication checked in the next cycle, quiet during reset
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

### hw/rtl/wsfd_pkg.sv
// ---------------------------------------------------------------------------
// wsfd_pkg
// Types and constants shared by the websocket frame deframer modules
// ---------------------------------------------------------------------------
`default_nettype none

package wsfd_pkg;

  typedef enum logic [2:0] {
    KIND_TEXT  = 3'd0,
    KIND_PING  = 3'd1,
    KIND_PONG  = 3'd2,
    KIND_CLOSE = 3'd3,
    KIND_ERROR = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ERR_RESERVED = 2'd0,
    ERR_UNMASKED = 2'd1,
    ERR_TOO_LONG = 2'd2,
    ERR_OPCODE   = 2'd3
  } err_t;

  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  localparam logic [7:0]  RSV_MASK       = 8'h70;
  localparam logic [6:0]  LEN_EXT16      = 7'd126;
  localparam logic [6:0]  LEN_MAX_SHORT  = 7'd125;
  localparam logic [3:0]  NEED_BASE      = 4'd2;
  localparam logic [3:0]  NEED_SHORT     = 4'd6;
  localparam logic [3:0]  NEED_EXT16     = 4'd8;
  localparam logic [3:0]  NEED_EXT64     = 4'd14;
  localparam logic [3:0]  HDR_MIN        = 4'd6;
  localparam logic [15:0] CODE_NORMAL    = 16'd1000;
  localparam logic [15:0] CODE_NO_BINARY = 16'd1003;
  localparam logic [7:0]  CHAR_CR        = 8'd13;
  localparam logic [7:0]  CHAR_LF        = 8'd10;
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd16384;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [6:0]  pong_length;
    logic [15:0] close_code;
    logic        with_reason;
    err_t        error_code;
    logic        last;
  } result_t;

  // results produced by one received byte
  typedef struct packed {
    logic [1:0]        count;
    result_t [2:0]     res;
  } step_t;

  function automatic result_t mk_result(kind_t k, logic [7:0] d, logic [6:0] pl,
                                        logic [15:0] cc, logic wr, err_t ec);
    result_t r;
    r.kind        = k;
    r.data        = d;
    r.pong_length = pl;
    r.close_code  = cc;
    r.with_reason = wr;
    r.error_code  = ec;
    r.last        = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/wsfd_core.sv
// ---------------------------------------------------------------------------
// wsfd_core
// Frame header parser, unmasker and opcode dispatch, one byte per transfer
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module wsfd_core #(
  parameter int PING_KEEP = 128,
  parameter int PONG_MAX  = 125
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             take,
  input  wire logic [7:0]       rx_byte,
  input  wire logic [15:0]      max_payload,
  output wsfd_pkg::step_t       step
);

  logic [3:0]  header_count, header_count_next;
  logic [3:0]  header_need, header_need_next;
  logic [3:0]  frame_opcode, frame_opcode_next;
  logic [31:0] length_accum, length_accum_next;
  logic        high_len_nz, high_len_nz_next;
  logic [31:0] key_word, key_word_next;
  logic [15:0] payload_total, payload_total_next;
  logic [15:0] payload_index, payload_index_next;
  logic [7:0]  close_first_byte, close_first_byte_next;
  logic        halted, halted_next;

  always_comb begin
    wsfd_pkg::result_t [2:0] res;
    logic [1:0]  n;
    logic        fault;
    logic        frame_end;
    logic [7:0]  key_byte;
    logic [7:0]  u;
    logic [16:0] idx_inc;
    logic        pay_done;
    logic [6:0]  plen;

    header_count_next     = header_count;
    header_need_next      = header_need;
    frame_opcode_next     = frame_opcode;
    length_accum_next     = length_accum;
    high_len_nz_next      = high_len_nz;
    key_word_next         = key_word;
    payload_total_next    = payload_total;
    payload_index_next    = payload_index;
    close_first_byte_next = close_first_byte;
    halted_next           = halted;
    res       = '0;
    n         = 2'd0;
    fault     = 1'b0;
    frame_end = 1'b0;

    unique case (payload_index[1:0])
      2'd0:    key_byte = key_word[31:24];
      2'd1:    key_byte = key_word[23:16];
      2'd2:    key_byte = key_word[15:8];
      default: key_byte = key_word[7:0];
    endcase
    u        = rx_byte ^ key_byte;
    idx_inc  = {1'b0, payload_index} + 17'd1;
    pay_done = idx_inc >= {1'b0, payload_total};

    // pong echoes nothing when the ping was cut short
    if ({1'b0, payload_total} > 17'(PING_KEEP)) begin
      plen = 7'd0;
    end else if (payload_total > 16'(PONG_MAX)) begin
      plen = 7'(PONG_MAX);
    end else begin
      plen = payload_total[6:0];
    end

    if (!halted) begin
      if (header_count < header_need) begin
        if (header_count == 4'd0) begin
          if ((rx_byte & wsfd_pkg::RSV_MASK) != 8'd0) begin
            res[n] = wsfd_pkg::mk_result(wsfd_pkg::KIND_ERROR, 8'd0, 7'd0, 16'd0, 1'b0,
                                         wsfd_pkg::ERR_RESERVED);
            n = n + 2'd1;
            halted_next = 1'b1;
            fault = 1'b1;
          end else begin
            frame_opcode_next = rx_byte[3:0];
          end
        end else if (header_count == 4'd1) begin
          if (!rx_byte[7]) begin
            res[n] = wsfd_pkg::mk_result(wsfd_pkg::KIND_ERROR, 8'd0, 7'd0, 16'd0, 1'b0,
                                         wsfd_pkg::ERR_UNMASKED);
            n = n + 2'd1;
            halted_next = 1'b1;
            fault = 1'b1;
          end else begin
            high_len_nz_next = 1'b0;
            if (rx_byte[6:0] <= wsfd_pkg::LEN_MAX_SHORT) begin
              header_need_next  = wsfd_pkg::NEED_SHORT;
              length_accum_next = {25'd0, rx_byte[6:0]};
            end else if (rx_byte[6:0] == wsfd_pkg::LEN_EXT16) begin
              header_need_next  = wsfd_pkg::NEED_EXT16;
              length_accum_next = 32'd0;
            end else begin
              header_need_next  = wsfd_pkg::NEED_EXT64;
              length_accum_next = 32'd0;
            end
          end
        end else if ({1'b0, header_count} + 5'd4 < {1'b0, header_need}) begin
          // upper four bytes of a 64-bit length only get checked for zero
          if (header_need == wsfd_pkg::NEED_EXT64 && header_count < 4'd6) begin
            if (rx_byte != 8'd0) high_len_nz_next = 1'b1;
          end else begin
            length_accum_next = {length_accum[23:0], rx_byte};
          end
        end else begin
          key_word_next = {key_word[23:0], rx_byte};
        end

        if (!fault) begin
          header_count_next = header_count + 4'd1;
          if (header_count_next >= wsfd_pkg::HDR_MIN &&
              header_count_next == header_need_next) begin
            if (high_len_nz_next || length_accum_next > {16'd0, max_payload}) begin
              res[n] = wsfd_pkg::mk_result(wsfd_pkg::KIND_ERROR, 8'd0, 7'd0, 16'd0, 1'b0,
                                           wsfd_pkg::ERR_TOO_LONG);
              n = n + 2'd1;
              halted_next = 1'b1;
            end else begin
              payload_total_next = length_accum_next[15:0];
              payload_index_next = 16'd0;
              unique case (frame_opcode_next)
                wsfd_pkg::OP_TEXT: begin
                  if (payload_total_next == 16'd0) begin
                    res[n] = wsfd_pkg::mk_result(wsfd_pkg::KIND_TEXT, wsfd_pkg::CHAR_CR,
                                                 7'd0, 16'd0, 1'b0, wsfd_pkg::ERR_RESERVED);
                    n = n + 2'd1;
                    res[n] = wsfd_pkg::mk_result(wsfd_pkg::KIND_TEXT, wsfd_pkg::CHAR_LF,
                                                 7'd0, 16'd0, 1'b0, wsfd_pkg::ERR_RESERVED);
                    n = n + 2'd1;
                    frame_end = 1'b1;
                  end
                end
                wsfd_pkg::OP_PING: begin
                  if (payload_total_next == 16'd0) begin
                    res[n] = wsfd_pkg::mk_result(wsfd_pkg::KIND_PONG, 8'd0, 7'd0, 16'd0,
                                                 1'b0, wsfd_pkg::ERR_RESERVED);
                    n = n + 2'd1;
                    frame_end = 1'b1;
                  end
                end
                wsfd_pkg::OP_PONG: begin
                  if (payload_total_next == 16'd0) frame_end = 1'b1;
                end
                wsfd_pkg::OP_CLOSE: begin
                  if (payload_total_next < 16'd2) begin
                    res[n] = wsfd_pkg::mk_result(wsfd_pkg::KIND_CLOSE, 8'd0, 7'd0,
                                                 wsfd_pkg::CODE_NORMAL, 1'b0,
                                                 wsfd_pkg::ERR_RESERVED);
                    n = n + 2'd1;
                    halted_next = 1'b1;
                  end
                end
                wsfd_pkg::OP_BINARY: begin
                  res[n] = wsfd_pkg::mk_result(wsfd_pkg::KIND_CLOSE, 8'd0, 7'd0,
                                               wsfd_pkg::CODE_NO_BINARY, 1'b1,
                                               wsfd_pkg::ERR_RESERVED);
                  n = n + 2'd1;
                  halted_next = 1'b1;
                end
                default: begin
                  res[n] = wsfd_pkg::mk_result(wsfd_pkg::KIND_ERROR, 8'd0, 7'd0, 16'd0,
                                               1'b0, wsfd_pkg::ERR_OPCODE);
                  n = n + 2'd1;
                  halted_next = 1'b1;
                end
              endcase
            end
          end
        end
      end else begin
        unique case (frame_opcode)
          wsfd_pkg::OP_TEXT: begin
            res[n] = wsfd_pkg::mk_result(wsfd_pkg::KIND_TEXT, u, 7'd0, 16'd0, 1'b0,
                                         wsfd_pkg::ERR_RESERVED);
            n = n + 2'd1;
            payload_index_next = idx_inc[15:0];
            if (pay_done) begin
              res[n] = wsfd_pkg::mk_result(wsfd_pkg::KIND_TEXT, wsfd_pkg::CHAR_CR, 7'd0,
                                           16'd0, 1'b0, wsfd_pkg::ERR_RESERVED);
              n = n + 2'd1;
              res[n] = wsfd_pkg::mk_result(wsfd_pkg::KIND_TEXT, wsfd_pkg::CHAR_LF, 7'd0,
                                           16'd0, 1'b0, wsfd_pkg::ERR_RESERVED);
              n = n + 2'd1;
              frame_end = 1'b1;
            end
          end
          wsfd_pkg::OP_PING: begin
            if ({1'b0, payload_index} < 17'(PING_KEEP)) begin
              res[n] = wsfd_pkg::mk_result(wsfd_pkg::KIND_PING, u, 7'd0, 16'd0, 1'b0,
                                           wsfd_pkg::ERR_RESERVED);
              n = n + 2'd1;
            end
            payload_index_next = idx_inc[15:0];
            if (pay_done) begin
              res[n] = wsfd_pkg::mk_result(wsfd_pkg::KIND_PONG, 8'd0, plen, 16'd0, 1'b0,
                                           wsfd_pkg::ERR_RESERVED);
              n = n + 2'd1;
              frame_end = 1'b1;
            end
          end
          wsfd_pkg::OP_PONG: begin
            payload_index_next = idx_inc[15:0];
            if (pay_done) frame_end = 1'b1;
          end
          wsfd_pkg::OP_CLOSE: begin
            // close code is big-endian over the first two payload bytes
            if (payload_index == 16'd0) begin
              close_first_byte_next = u;
              payload_index_next    = 16'd1;
            end else begin
              res[n] = wsfd_pkg::mk_result(wsfd_pkg::KIND_CLOSE, 8'd0, 7'd0,
                                           {close_first_byte, u}, 1'b0,
                                           wsfd_pkg::ERR_RESERVED);
              n = n + 2'd1;
              halted_next = 1'b1;
            end
          end
          default: begin
            halted_next = 1'b1;
          end
        endcase
      end
    end

    if (frame_end) begin
      header_count_next  = 4'd0;
      header_need_next   = wsfd_pkg::NEED_BASE;
      length_accum_next  = 32'd0;
      payload_total_next = 16'd0;
      payload_index_next = 16'd0;
    end

    if (n != 2'd0) res[n - 2'd1].last = 1'b1;
    step.count = n;
    step.res   = res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count     <= 4'd0;
      header_need      <= wsfd_pkg::NEED_BASE;
      frame_opcode     <= 4'd0;
      length_accum     <= 32'd0;
      high_len_nz      <= 1'b0;
      key_word         <= 32'd0;
      payload_total    <= 16'd0;
      payload_index    <= 16'd0;
      close_first_byte <= 8'd0;
      halted           <= 1'b0;
    end else if (take) begin
      header_count     <= header_count_next;
      header_need      <= header_need_next;
      frame_opcode     <= frame_opcode_next;
      length_accum     <= length_accum_next;
      high_len_nz      <= high_len_nz_next;
      key_word         <= key_word_next;
      payload_total    <= payload_total_next;
      payload_index    <= payload_index_next;
      close_first_byte <= close_first_byte_next;
      halted           <= halted_next;
    end
  end

  `ASSERT_SAME(a_hdr_count_bound, clk, rst, !halted, header_count <= header_need,
               "header count past need")
  `ASSERT_SAME(a_payload_idx_bound, clk, rst, !halted && header_count == header_need,
               payload_index < payload_total, "payload index reached total without frame end")
  `ASSERT_NEXT(a_halt_sticks, clk, rst, halted, halted, "halt released without reset")

endmodule

`default_nettype wire

### hw/rtl/websocket_frame_deframer_unit.sv
// ---------------------------------------------------------------------------
// websocket_frame_deframer_unit
// Client-to-server websocket deframer: header checks, unmasking, dispatch
// ---------------------------------------------------------------------------
// Takes one masked websocket stream byte per transfer on the s_ side and
// gives text bytes (with CR LF at frame end), ping bytes, pong requests,
// a close code or an error on the m_ side. A byte is taken every cycle as
// long as it causes at most one result and m_tready holds; the three-entry
// result buffer sets the rate, so a byte that ends a text frame (three
// results) or a ping frame (two results) holds the input side until one
// entry is left. After a close or an error the block drops all input until
// rst. The user must write max_payload through cfg_we and cfg_wdata only
// while the block is idle (not enforced); no clearing pass after reset.
`default_nettype none
`include "assert_macros.svh"

module websocket_frame_deframer_unit #(
  parameter int PING_KEEP = 128,
  parameter int PONG_MAX  = 125
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,     // max_payload
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,       // [7:0] rx_byte
  input  wire logic        s_tlast,       // end_of_read
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [7:0] data, [14:8] pong_length, [30:15] close_code, [31] with_reason,
  // [33:32] error_code, [39:34] zero
  output logic [39:0]      m_tdata,
  output logic [2:0]       m_tuser,       // [2:0] kind
  output logic             m_tlast        // last
);

  logic [15:0]             max_payload;
  wsfd_pkg::step_t         step;
  wsfd_pkg::result_t [2:0] q;
  logic [1:0]              cnt;
  logic                    push;
  logic                    pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= wsfd_pkg::MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      max_payload <= cfg_wdata;
    end
  end

  // read markers carry nothing for the parser
  assign s_tready = (cnt == 2'd0) || (cnt == 2'd1 && m_tready) || (s_tlast && 1'b0);
  assign push     = s_tvalid && s_tready;
  assign pop      = m_tvalid && m_tready;

  wsfd_core #(
    .PING_KEEP (PING_KEEP),
    .PONG_MAX  (PONG_MAX)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .take        (push),
    .rx_byte     (s_tdata),
    .max_payload (max_payload),
    .step        (step)
  );

  // a transfer in is only taken when the buffer is empty or empties this cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (push) begin
      cnt <= step.count;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q <= step.res;
    end else if (pop) begin
      q[0] <= q[1];
      q[1] <= q[2];
    end
  end

  assign m_tvalid = cnt != 2'd0;
  assign m_tuser  = q[0].kind;
  assign m_tlast  = q[0].last;
  assign m_tdata  = {6'd0, q[0].error_code, q[0].with_reason, q[0].close_code,
                     q[0].pong_length, q[0].data};

  `ASSERT_SAME(a_tail_is_last, clk, rst, cnt != 2'd0, q[cnt - 2'd1].last, "buffered group not closed by last")
  `ASSERT_NEXT(a_quiet_after_end, clk, rst, pop && (m_tuser == wsfd_pkg::KIND_ERROR || m_tuser == wsfd_pkg::KIND_CLOSE), !m_tvalid, "result after close or error")

endmodule

`default_nettype wire
